@@ hdl/axis_angle_rotation_matrix_unit_macros.svh @@
// Assertion macros for the axis-angle rotation matrix unit.
// Used by the top level only; needs nothing else.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_MACROS_SVH

// Consequence in the same cycle.
`define AARM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence in the next cycle.
`define AARM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/aarm_pkg.sv @@
// Shared constants, table type and table builder for the rotation matrix unit.
// No dependencies.
`timescale 1ns / 1ps
package aarm_pkg;

  localparam int VALUE_FRAC_BITS_DEF = 16;
  localparam int AXIS_WIDTH_DEF      = 16;
  localparam int TABLE_STEPS         = 360;
  localparam int ANGLE_FRAC_BITS     = 8;
  localparam int QTAB_LEN            = 91;
  localparam int ROM_FRAC            = 30;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  // Multiple of the angle period that makes any 32-bit angle non-negative.
  localparam logic [32:0] ANGLE_OFFSET = 33'd2147512320;
  // Period is 45 * 2^11 in angle LSBs.
  localparam int HI_SHIFT  = 11;
  localparam int MOD_BASE  = (TABLE_STEPS << ANGLE_FRAC_BITS) >> HI_SHIFT;
  localparam int ANG_HI_W  = 33 - HI_SHIFT;
  localparam int MAG_W     = 24;
  localparam int SQRT_BITS = 31;

  typedef logic [30:0] qtab_t [QTAB_LEN];

  // First-quadrant sine, rounded to frac fraction bits. Elaboration only.
  function automatic qtab_t build_qtab(input int frac);
    qtab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    int sh;
    sh = ROM_FRAC - frac;
    for (int d = 0; d < QTAB_LEN; d++) begin
      x = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
      x2 = (x * x) >> ROM_FRAC;
      term = x;
      sum = longint'(x);
      for (int k = 1; k < 16; k++) begin
        if (term != 64'd0) begin
          term = ((term * x2) >> ROM_FRAC) / 64'((2 * k) * (2 * k + 1));
          if ((k & 1) != 0) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << ROM_FRAC)) sum = longint'(1) << ROM_FRAC;
      if (sh > 0) sum = (sum + (longint'(1) << (sh - 1))) >>> sh;
      tab[d] = 31'(sum);
    end
    return tab;
  endfunction

endpackage

@@ hdl/aarm_in_if.sv @@
// Input channel: angle and rotation axis, valid/ready.
// Depends on aarm_pkg.
`timescale 1ns / 1ps
interface aarm_in_if import aarm_pkg::*; #(
  parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [31:0]           angle_deg;
  logic signed [AXIS_WIDTH-1:0] axis_x;
  logic signed [AXIS_WIDTH-1:0] axis_y;
  logic signed [AXIS_WIDTH-1:0] axis_z;

  modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

@@ hdl/aarm_out_if.sv @@
// Output channel: one matrix entry per transaction, valid/ready.
// Depends on aarm_pkg.
`timescale 1ns / 1ps
interface aarm_out_if import aarm_pkg::*; #(
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [3:0]                        element_index;
  logic signed [VALUE_FRAC_BITS+1:0] element_value;
  logic                              axis_error;
  logic                              last;

  modport source (output valid, element_index, element_value, axis_error, last, input ready);
  modport sink   (input valid, element_index, element_value, axis_error, last, output ready);
endinterface

@@ hdl/aarm_core.sv @@
// Pipelined matrix computation: axis normalize, sqrt, divide, sin/cos lerp, products.
// Depends on aarm_pkg and aarm_in_if.
`timescale 1ns / 1ps
module aarm_core import aarm_pkg::*; #(
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF,
  parameter int AXIS_WIDTH      = AXIS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  aarm_in_if.sink                           din,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              res_zero,
  output logic signed [VALUE_FRAC_BITS+1:0] res_m [9]
);

  localparam int F     = VALUE_FRAC_BITS;
  localparam int VW    = F + 2;
  localparam int WW    = (AXIS_WIDTH > 25) ? AXIS_WIDTH : 25;
  localparam int RSMAX = (AXIS_WIDTH > 24) ? AXIS_WIDTH - 24 : 0;
  localparam int KW    = (RSMAX > 0) ? $clog2(RSMAX + 1) : 1;
  localparam int HW    = ANG_HI_W;
  localparam int NSQ   = SQRT_BITS;
  localparam int SW    = 2 * NSQ + 1;
  localparam int NW    = F + MAG_W + 7;
  localparam int QW    = F + 2;
  localparam int UW    = F + 3;
  localparam int EW    = UW + 1;
  localparam int PW    = VW + 10;
  localparam int NS    = NSQ + QW + 13;

  localparam qtab_t QTAB = build_qtab(F);
  localparam logic [WW-1:0] LIM_POS = WW'((1 << MAG_W) - 1);
  localparam logic [WW-1:0] LIM_NEG = WW'((1 << MAG_W) - 2);
  localparam logic signed [2*UW-1:0] HALF_LSB = (2 * UW)'(1) << (F - 1);
  localparam logic signed [UW-1:0] ONE_U = UW'(1) << F;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW - 1){1'b0}}};

  typedef struct packed {
    logic                    zero;
    logic [2:0]              sgn;
    logic [2:0][MAG_W-1:0]   mag;
    logic signed [VW-1:0]    s;
    logic signed [VW-1:0]    co;
  } side_t;

  function automatic logic signed [VW-1:0] sine_at(input logic [8:0] d);
    logic [6:0]    q;
    logic          neg;
    logic [VW-1:0] m;
    if (d <= 9'd90) begin
      q = d[6:0];
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      q = 7'(9'd180 - d);
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      q = 7'(d - 9'd180);
      neg = 1'b1;
    end else begin
      q = 7'(9'd360 - d);
      neg = 1'b1;
    end
    m = {1'b0, QTAB[q][VW-2:0]};
    return neg ? -m : m;
  endfunction

  function automatic logic [8:0] add_quarter(input logic [8:0] d);
    logic [9:0] t;
    t = 10'(d) + 10'd90;
    if (t >= 10'(TABLE_STEPS)) t = t - 10'(TABLE_STEPS);
    return t[8:0];
  endfunction

  function automatic logic signed [UW-1:0] mulq(input logic signed [UW-1:0] a,
                                               input logic signed [UW-1:0] b);
    logic signed [2*UW-1:0] p;
    p = (2 * UW)'(a) * (2 * UW)'(b);
    p = p + HALF_LSB;
    return UW'(p >>> F);
  endfunction

  function automatic logic signed [VW-1:0] sat(input logic signed [EW-1:0] v);
    if (v > EW'(VMAX)) return VMAX;
    if (v < EW'(VMIN)) return VMIN;
    return VW'(v);
  endfunction

  logic [NS-1:0] vld;
  logic          adv;

  assign adv = !vld[NS-1] || res_ready;
  assign din.ready = adv;
  assign res_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], din.valid};
    end
  end

  // ---------------- front stages
  logic signed [31:0]    s1_a;
  logic signed [WW-1:0]  s1_c [3];
  logic [HW-1:0]         s2_hi;
  logic [HI_SHIFT-1:0]   s2_lo;
  logic signed [WW-1:0]  s2_c [3];
  logic [KW-1:0]         s2_k;
  logic [HW-1:0]         s3_hi;
  logic [HI_SHIFT-1:0]   s3_lo;
  logic [2:0]            s3_sgn;
  logic [MAG_W-1:0]      s3_mag [3];
  logic [HW-1:0]         s4_hi;
  logic [HI_SHIFT-1:0]   s4_lo;
  logic [2:0]            s4_sgn;
  logic [MAG_W-1:0]      s4_mag [3];
  logic [MAG_W-1:0]      s4_mx;
  logic [8:0]            s5_idx;
  logic [7:0]            s5_frac;
  logic [2:0]            s5_sgn;
  logic [MAG_W-1:0]      s5_mag [3];
  logic [4:0]            s5_j;
  logic                  s5_zero;
  logic signed [VW-1:0]  s6_ts0, s6_ts1, s6_tc0, s6_tc1;
  logic [7:0]            s6_frac;
  logic [2:0]            s6_sgn;
  logic [MAG_W-1:0]      s6_ms [3];
  logic                  s6_zero;
  logic signed [VW-1:0]  s7_ts0, s7_tc0;
  logic signed [PW-1:0]  s7_ps, s7_pc;
  logic [2:0]            s7_sgn;
  logic [MAG_W-1:0]      s7_ms [3];
  logic [2*MAG_W-1:0]    s7_sq [3];
  logic                  s7_zero;

  logic [32:0]           ang_x;
  logic                  k_ok;
  logic [WW-1:0]         k_ev;
  logic [WW-1:0]         k_lim;
  logic [KW-1:0]         k_sel;
  logic signed [WW-1:0]  sh_c [3];
  logic signed [24:0]    c25 [3];
  logic [HW-1:0]         md3, md4;
  logic [5:0]            md5;
  logic [16:0]           ang_r;
  logic [MAG_W-1:0]      mx;
  logic [4:0]            lead;
  logic [8:0]            nx_idx;
  logic signed [VW:0]    ds, dc;
  logic [2*MAG_W+1:0]    l2;

  assign ang_x = 33'(s1_a) + ANGLE_OFFSET;

  always_comb begin
    k_sel = KW'(RSMAX);
    k_ok = 1'b1;
    k_ev = '0;
    k_lim = '0;
    for (int kk = RSMAX; kk >= 0; kk--) begin
      k_ok = 1'b1;
      for (int n = 0; n < 3; n++) begin
        k_ev = s1_c[n][WW-1] ? ~s1_c[n] : s1_c[n];
        k_lim = s1_c[n][WW-1] ? LIM_NEG : LIM_POS;
        if ((k_ev >> kk) > k_lim) k_ok = 1'b0;
      end
      if (k_ok) k_sel = KW'(kk);
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      sh_c[n] = s2_c[n] >>> s2_k;
      c25[n] = sh_c[n][24:0];
    end
  end

  always_comb begin
    md3 = s2_hi;
    for (int i = 16; i >= 9; i--) begin
      if (md3 >= (HW'(MOD_BASE) << i)) md3 = md3 - (HW'(MOD_BASE) << i);
    end
    md4 = s3_hi;
    for (int i = 8; i >= 1; i--) begin
      if (md4 >= (HW'(MOD_BASE) << i)) md4 = md4 - (HW'(MOD_BASE) << i);
    end
    md5 = (s4_hi >= HW'(MOD_BASE)) ? 6'(s4_hi - HW'(MOD_BASE)) : s4_hi[5:0];
    ang_r = {md5, s4_lo};
  end

  always_comb begin
    mx = s3_mag[0];
    if (s3_mag[1] > mx) mx = s3_mag[1];
    if (s3_mag[2] > mx) mx = s3_mag[2];
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (s4_mx[i]) lead = 5'(i);
    end
  end

  assign nx_idx = (s5_idx == 9'(TABLE_STEPS - 1)) ? 9'd0 : s5_idx + 9'd1;
  assign ds = (VW + 1)'(s6_ts1) - (VW + 1)'(s6_ts0);
  assign dc = (VW + 1)'(s6_tc1) - (VW + 1)'(s6_tc0);
  assign l2 = (2 * MAG_W + 2)'(s7_sq[0]) + (2 * MAG_W + 2)'(s7_sq[1])
            + (2 * MAG_W + 2)'(s7_sq[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a <= din.angle_deg;
      s1_c[0] <= WW'(din.axis_x);
      s1_c[1] <= WW'(din.axis_y);
      s1_c[2] <= WW'(din.axis_z);

      s2_hi <= ang_x[32:HI_SHIFT];
      s2_lo <= ang_x[HI_SHIFT-1:0];
      s2_c <= s1_c;
      s2_k <= k_sel;

      s3_hi <= md3;
      s3_lo <= s2_lo;
      for (int n = 0; n < 3; n++) begin
        s3_sgn[n] <= c25[n][24];
        s3_mag[n] <= c25[n][24] ? MAG_W'(-c25[n]) : c25[n][MAG_W-1:0];
      end

      s4_hi <= md4;
      s4_lo <= s3_lo;
      s4_sgn <= s3_sgn;
      s4_mag <= s3_mag;
      s4_mx <= mx;

      s5_idx <= ang_r[16:8];
      s5_frac <= ang_r[7:0];
      s5_sgn <= s4_sgn;
      s5_mag <= s4_mag;
      s5_j <= 5'(MAG_W - 1) - lead;
      s5_zero <= (s4_mx == '0);

      s6_ts0 <= sine_at(s5_idx);
      s6_ts1 <= sine_at(nx_idx);
      s6_tc0 <= sine_at(add_quarter(s5_idx));
      s6_tc1 <= sine_at(add_quarter(nx_idx));
      s6_frac <= s5_frac;
      s6_sgn <= s5_sgn;
      for (int n = 0; n < 3; n++) s6_ms[n] <= s5_mag[n] << s5_j;
      s6_zero <= s5_zero;

      s7_ts0 <= s6_ts0;
      s7_tc0 <= s6_tc0;
      s7_ps <= PW'(ds) * PW'($signed({1'b0, s6_frac})) + PW'(128);
      s7_pc <= PW'(dc) * PW'($signed({1'b0, s6_frac})) + PW'(128);
      s7_sgn <= s6_sgn;
      s7_ms <= s6_ms;
      for (int n = 0; n < 3; n++) s7_sq[n] <= (2 * MAG_W)'(s6_ms[n]) * (2 * MAG_W)'(s6_ms[n]);
      s7_zero <= s6_zero;
    end
  end

  // ---------------- square root, one result bit per stage
  logic [SW-1:0]  sq_rem  [NSQ+1];
  logic [NSQ-1:0] sq_root [NSQ+1];
  side_t          sq_side [NSQ+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0] <= SW'({l2, 12'b0});
      sq_root[0] <= '0;
      sq_side[0].zero <= s7_zero;
      sq_side[0].sgn <= s7_sgn;
      for (int n = 0; n < 3; n++) sq_side[0].mag[n] <= s7_ms[n];
      sq_side[0].s <= VW'(PW'(s7_ts0) + (s7_ps >>> ANGLE_FRAC_BITS));
      sq_side[0].co <= VW'(PW'(s7_tc0) + (s7_pc >>> ANGLE_FRAC_BITS));
    end
  end

  for (genvar n = 0; n < NSQ; n++) begin : g_sqrt
    localparam int B = NSQ - 1 - n;
    logic [SW-1:0] trial;
    assign trial = (SW'(sq_root[n]) << (B + 1)) | (SW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq_rem[n] >= trial) begin
          sq_rem[n+1] <= sq_rem[n] - trial;
          sq_root[n+1] <= sq_root[n] | (NSQ'(1) << B);
        end else begin
          sq_rem[n+1] <= sq_rem[n];
          sq_root[n+1] <= sq_root[n];
        end
        sq_side[n+1] <= sq_side[n];
      end
    end
  end

  // ---------------- three restoring dividers, one quotient bit per stage
  logic [2:0][NW-1:0] dv_rem  [QW+1];
  logic [2:0][QW-1:0] dv_q    [QW+1];
  logic [NSQ-1:0]     dv_root [QW+1];
  side_t              dv_side [QW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        dv_rem[0][l] <= (NW'(sq_side[NSQ].mag[l]) << (F + 6)) + NW'(sq_root[NSQ] >> 1);
        dv_q[0][l] <= '0;
      end
      dv_root[0] <= sq_root[NSQ];
      dv_side[0] <= sq_side[NSQ];
    end
  end

  for (genvar n = 0; n < QW; n++) begin : g_div
    localparam int B = QW - 1 - n;
    logic [NW:0] dsh;
    assign dsh = (NW + 1)'(dv_root[n]) << B;
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          if ({1'b0, dv_rem[n][l]} >= dsh) begin
            dv_rem[n+1][l] <= NW'({1'b0, dv_rem[n][l]} - dsh);
            dv_q[n+1][l] <= dv_q[n][l] | (QW'(1) << B);
          end else begin
            dv_rem[n+1][l] <= dv_rem[n][l];
            dv_q[n+1][l] <= dv_q[n][l];
          end
        end
        dv_root[n+1] <= dv_root[n];
        dv_side[n+1] <= dv_side[n];
      end
    end
  end

  // ---------------- unit axis, products, sums
  logic signed [UW-1:0] u   [3];
  logic                 u_zero;
  logic signed [VW-1:0] u_s, u_co;
  logic signed [UW-1:0] p1_t;
  logic signed [UW-1:0] p1_in [6];
  logic signed [UW-1:0] p1_su [3];
  logic signed [VW-1:0] p1_co;
  logic                 p1_zero;
  logic signed [UW-1:0] p2_out [6];
  logic signed [UW-1:0] p2_su [3];
  logic signed [VW-1:0] p2_co;
  logic                 p2_zero;
  logic signed [EW-1:0] co_e;

  assign co_e = EW'(p2_co);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        u[l] <= dv_side[QW].sgn[l] ? -UW'(dv_q[QW][l]) : UW'(dv_q[QW][l]);
      end
      u_zero <= dv_side[QW].zero;
      u_s <= dv_side[QW].s;
      u_co <= dv_side[QW].co;

      p1_t <= ONE_U - UW'(u_co);
      p1_in[0] <= mulq(u[0], u[0]);
      p1_in[1] <= mulq(u[1], u[1]);
      p1_in[2] <= mulq(u[2], u[2]);
      p1_in[3] <= mulq(u[0], u[1]);
      p1_in[4] <= mulq(u[0], u[2]);
      p1_in[5] <= mulq(u[1], u[2]);
      for (int l = 0; l < 3; l++) p1_su[l] <= mulq(UW'(u_s), u[l]);
      p1_co <= u_co;
      p1_zero <= u_zero;

      for (int i = 0; i < 6; i++) p2_out[i] <= mulq(p1_t, p1_in[i]);
      p2_su <= p1_su;
      p2_co <= p1_co;
      p2_zero <= p1_zero;

      res_m[0] <= sat(EW'(p2_out[0]) + co_e);
      res_m[1] <= sat(EW'(p2_out[3]) + EW'(p2_su[2]));
      res_m[2] <= sat(EW'(p2_out[4]) - EW'(p2_su[1]));
      res_m[3] <= sat(EW'(p2_out[3]) - EW'(p2_su[2]));
      res_m[4] <= sat(EW'(p2_out[1]) + co_e);
      res_m[5] <= sat(EW'(p2_out[5]) + EW'(p2_su[0]));
      res_m[6] <= sat(EW'(p2_out[4]) + EW'(p2_su[1]));
      res_m[7] <= sat(EW'(p2_out[5]) - EW'(p2_su[0]));
      res_m[8] <= sat(EW'(p2_out[2]) + co_e);
      res_zero <= p2_zero;
    end
  end

endmodule

@@ hdl/axis_angle_rotation_matrix_unit.sv @@
// Channel   | dir | payload
// din       | in  | angle_deg, axis_x, axis_y, axis_z
// dout      | out | element_index, element_value, axis_error, last
//
// One transaction on din yields 16 transactions on dout (1 for a zero axis),
// so a new input is taken as each matrix ends (every cycle for zero axes) while dout stays ready.
// The path from input to first entry runs through the 31-stage square root and the
// (VALUE_FRAC_BITS + 2)-stage dividers.
// Synchronous active-high reset clears valid state only; tables are constants.
// A dout stall holds the core pipeline once a result waits at its end; nothing is dropped or repeated.
// Depends on aarm_pkg, aarm_in_if, aarm_out_if, aarm_core and the macros header.
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_unit_macros.svh"
module axis_angle_rotation_matrix_unit import aarm_pkg::*; #(
  parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF,
  parameter int AXIS_WIDTH      = AXIS_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  aarm_in_if.sink    din,
  aarm_out_if.source dout
);

  localparam int VW = VALUE_FRAC_BITS + 2;
  localparam logic signed [VW-1:0] ONE_V = VW'(1) << VALUE_FRAC_BITS;

  logic                 res_valid;
  logic                 res_zero;
  logic signed [VW-1:0] res_m [9];
  logic                 take;
  logic                 last_now;
  logic                 busy;
  logic [3:0]           cnt;
  logic                 err;
  logic signed [VW-1:0] mv [9];

  aarm_core #(
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
    .AXIS_WIDTH      (AXIS_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .res_valid (res_valid),
    .res_ready (take),
    .res_zero  (res_zero),
    .res_m     (res_m)
  );

  assign last_now = busy && (err || cnt == 4'd15);
  assign take = !busy || (dout.ready && last_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (res_valid && take) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy && dout.ready) begin
      if (last_now) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && take) begin
      err <= res_zero;
      mv <= res_m;
    end
  end

  assign dout.valid = busy;
  assign dout.element_index = cnt;
  assign dout.axis_error = err;
  assign dout.last = last_now;

  always_comb begin
    if (err) begin
      dout.element_value = '0;
    end else begin
      unique case (cnt)
        4'd0:    dout.element_value = mv[0];
        4'd1:    dout.element_value = mv[1];
        4'd2:    dout.element_value = mv[2];
        4'd4:    dout.element_value = mv[3];
        4'd5:    dout.element_value = mv[4];
        4'd6:    dout.element_value = mv[5];
        4'd8:    dout.element_value = mv[6];
        4'd9:    dout.element_value = mv[7];
        4'd10:   dout.element_value = mv[8];
        4'd15:   dout.element_value = ONE_V;
        default: dout.element_value = '0;
      endcase
    end
  end

  `AARM_ASSERT_NOW(a_err_single, clk, rst, dout.valid && dout.axis_error, dout.last && dout.element_index == 4'd0, "error transaction must be a single entry")
  `AARM_ASSERT_NOW(a_matrix_end, clk, rst, dout.valid && !dout.axis_error && dout.last, dout.element_index == 4'd15, "matrix must end at entry 15")
  `AARM_ASSERT_NEXT(a_idx_step, clk, rst, dout.valid && dout.ready && !dout.last, dout.valid && dout.element_index == $past(dout.element_index) + 4'd1, "entry index must step by one")

endmodule
